// File: src/first_fit_block_allocator_unit_assert.svh
// Assertion macros for the first-fit allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define FFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/ffba_pkg.sv
// Types and codes shared by the first-fit allocator modules.
package ffba_pkg;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_DEFRAG = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_ILLEGAL = 2'd2;

    localparam logic [15:0] HANDLE_MAX = 16'hFFFF;
    localparam logic [8:0]  MEM_SIZE_RST = 9'd256;

    typedef struct packed {
        logic [1:0]  op;
        logic [8:0]  length;
        logic [8:0]  start_cell;
        logic        has_start;
        logic [15:0] handle;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_handle;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic sort;
        logic phase;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_ERASE,
        ST_SORT,
        ST_RESP
    } t_state;

endpackage

// File: src/ffba_cell.sv
// One owner cell of the chain: shifts toward the head or does an odd-even compaction step.
module ffba_cell import ffba_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_m,
    input  logic [15:0]   i_left,
    input  logic [15:0]   i_right,
    output logic [15:0]   o_val
);

    logic [15:0] r_val;
    logic [15:0] n_val;
    logic        w_left_role;
    logic        w_right_role;

    // left of a pair on the matching phase, right partner inside the used range
    assign w_left_role  = ((IDX % 2 == 1) == i_ctl.phase) && (CW'(IDX + 1) < i_m);
    assign w_right_role = (IDX >= 1) && ((IDX % 2 == 0) == i_ctl.phase) && (CW'(IDX) < i_m);

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_right;
        end else if (i_ctl.sort) begin
            if (w_left_role && r_val == '0 && i_right != '0) begin
                n_val = i_right;
            end
            if (w_right_role && i_left == '0 && r_val != '0) begin
                n_val = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

// File: src/first_fit_block_allocator_unit.sv
// First-fit allocator: a ring of MEM_CELLS owner cells rotated past one head.
// Allocate: two full rotations (one when no run fits, none for length 0 or handles used up).
// Erase: one rotation; defragment: MEM_CELLS odd-even rounds.
// One item at a time; the rotation length sets the rate.
// Synchronous active-low reset clears all cells, the handle counter, mem_size to 256.
module first_fit_block_allocator_unit import ffba_pkg::*; #(
    parameter int MEM_CELLS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word,
    input  logic      i_cfg_we,
    input  logic [8:0] i_cfg_data
);

`include "first_fit_block_allocator_unit_assert.svh"

    localparam int CW = $clog2(MEM_CELLS + 1);
    localparam int W  = (CW > 9) ? CW : 9;

    logic [15:0] w_val [MEM_CELLS];
    logic [15:0] n_head;
    logic [15:0] w_head;
    t_cell_ctl   w_ctl;
    logic [CW-1:0] w_m;

    t_state      r_state, n_state;
    t_in_word    r_item, n_item;
    logic [8:0]  r_mem_size;
    logic [CW-1:0] r_t, n_t;
    logic [CW-1:0] r_run, n_run;
    logic        r_found, n_found;
    logic [W-1:0] r_p, n_p;
    logic [W-1:0] r_end, n_end;
    logic        r_present, n_present;
    logic [15:0] r_last, n_last;
    logic [15:0] r_newh, n_newh;
    t_out_word   r_res, n_res;
    logic        r_o_valid, n_o_valid;
    t_out_word   r_o_word, n_o_word;

    logic [W-1:0] w_t;
    logic [W-1:0] w_first;
    logic [W-1:0] w_len;
    logic         w_last_t;
    logic         w_in_range;
    logic         w_in_acc;

    assign w_m = (W'(r_mem_size) > W'(MEM_CELLS)) ? CW'(MEM_CELLS) : CW'(r_mem_size);
    assign w_head = w_val[0];
    assign w_t = W'(r_t);
    assign w_len = W'(r_item.length);
    assign w_first = (r_item.has_start && r_item.start_cell > 9'd1)
                     ? W'(r_item.start_cell) - W'(1) : '0;
    assign w_last_t = (r_t == CW'(MEM_CELLS - 1));
    assign w_in_range = (r_t < w_m);
    assign w_in_acc = i_valid && !o_stall;

    genvar k;
    generate
        for (k = 0; k < MEM_CELLS; k++) begin : g_cell
            logic [15:0] w_left;
            logic [15:0] w_right;
            if (k == 0) begin : g_l0
                assign w_left = '0;
            end else begin : g_ln
                assign w_left = w_val[k-1];
            end
            if (k == MEM_CELLS - 1) begin : g_rt
                assign w_right = n_head;
            end else begin : g_rn
                assign w_right = w_val[k+1];
            end
            ffba_cell #(.IDX(k), .CW(CW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_m     (w_m),
                .i_left  (w_left),
                .i_right (w_right),
                .o_val   (w_val[k])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_t       = r_t;
        n_run     = r_run;
        n_found   = r_found;
        n_p       = r_p;
        n_end     = r_end;
        n_present = r_present;
        n_last    = r_last;
        n_newh    = r_newh;
        n_res     = r_res;
        n_head    = w_head;
        w_ctl     = '0;
        o_stall   = (r_state != ST_IDLE);
        n_o_valid = r_o_valid && i_stall;
        n_o_word  = r_o_word;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_item    = i_word;
                    n_t       = '0;
                    n_run     = '0;
                    n_found   = 1'b0;
                    n_present = 1'b0;
                    unique case (i_word.op)
                        OP_ALLOC: begin
                            if (i_word.length == '0 || r_last == HANDLE_MAX) begin
                                n_res   = '{status: STAT_NOSPACE, new_handle: '0};
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_ERASE:  n_state = ST_ERASE;
                        OP_DEFRAG: n_state = ST_SORT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                w_ctl.shift = 1'b1;
                if (!r_found && w_t >= w_first && w_in_range) begin
                    if (w_head != '0) begin
                        n_run = '0;
                    end else begin
                        n_run = r_run + CW'(1);
                        if (W'(r_run) + W'(1) == w_len) begin
                            n_found = 1'b1;
                            n_p     = w_t + W'(1) - w_len;
                            n_end   = w_t;
                        end
                    end
                end
                n_t = r_t + CW'(1);
                if (w_last_t) begin
                    n_t = '0;
                    if (n_found) begin
                        n_newh  = r_last + 16'd1;
                        n_state = ST_FILL;
                    end else begin
                        n_res   = '{status: STAT_NOSPACE, new_handle: '0};
                        n_state = ST_RESP;
                    end
                end
            end
            ST_FILL: begin
                w_ctl.shift = 1'b1;
                if (w_t >= r_p && w_t <= r_end) begin
                    n_head = r_newh;
                end
                n_t = r_t + CW'(1);
                if (w_last_t) begin
                    n_t     = '0;
                    n_last  = r_newh;
                    n_res   = '{status: STAT_OK, new_handle: r_newh};
                    n_state = ST_RESP;
                end
            end
            ST_ERASE: begin
                w_ctl.shift = 1'b1;
                if (w_in_range && w_head == r_item.handle) begin
                    n_head = '0;
                    if (r_item.handle != '0) begin
                        n_present = 1'b1;
                    end
                end
                n_t = r_t + CW'(1);
                if (w_last_t) begin
                    n_t = '0;
                    if (n_present) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_res   = '{status: STAT_ILLEGAL, new_handle: '0};
                        n_state = ST_RESP;
                    end
                end
            end
            ST_SORT: begin
                w_ctl.sort  = 1'b1;
                w_ctl.phase = r_t[0];
                n_t = r_t + CW'(1);
                if (w_last_t) begin
                    n_t     = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                // wait for the output register to free up
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_word  = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_t        <= '0;
            r_run      <= '0;
            r_found    <= 1'b0;
            r_present  <= 1'b0;
            r_last     <= '0;
            r_o_valid  <= 1'b0;
            r_mem_size <= MEM_SIZE_RST;
        end else begin
            r_state   <= n_state;
            r_t       <= n_t;
            r_run     <= n_run;
            r_found   <= n_found;
            r_present <= n_present;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_p      <= n_p;
        r_end    <= n_end;
        r_newh   <= n_newh;
        r_res    <= n_res;
        r_o_word <= n_o_word;
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

    `FFBA_ASSERT_IMP(a_fill_found, r_state == ST_FILL, r_found, "fill pass without a found run")
    `FFBA_ASSERT_IMP(a_handle_only_ok, o_valid && o_word.status != STAT_OK,
        o_word.new_handle == '0, "handle reported on a failed word")
    `FFBA_ASSERT(a_run_bound, W'(r_run) <= W'(MEM_CELLS), "free run count past table size")

endmodule

// File: tb/ffba_alloc_checker.sv
// Allocator checker: owner-table prediction and result comparison.
`timescale 1ns / 1ps
module ffba_alloc_checker import ffba_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    output int         o_fail_cnt,
    output int         o_pending
);

    logic [15:0] owner_tbl [256];
    logic [15:0] handle_ctr;
    logic [8:0]  cell_cnt;
    t_out_word   result_q [$];
    int          fails;

    assign o_fail_cnt = fails;
    assign o_pending  = result_q.size();

    task automatic push_result(input logic [1:0] st, input logic [15:0] h);
        t_out_word r;
        r.status     = st;
        r.new_handle = h;
        result_q = {result_q, r};
    endtask

    task automatic apply_word(input t_in_word w);
        int m;
        int first;
        int run;
        int i;
        int hit;
        int wr;
        m = (cell_cnt > 256) ? 256 : int'(cell_cnt);
        case (w.op)
            OP_ALLOC: begin
                first = (w.has_start && w.start_cell > 1) ? int'(w.start_cell) - 1 : 0;
                hit = -1;
                run = 0;
                if (w.length != 0 && handle_ctr != HANDLE_MAX) begin
                    for (i = first; i < m && hit < 0; i++) begin
                        if (owner_tbl[i] != 0) run = 0;
                        else begin
                            run++;
                            if (run == int'(w.length)) hit = i;
                        end
                    end
                end
                if (hit < 0) push_result(STAT_NOSPACE, 16'd0);
                else begin
                    handle_ctr = handle_ctr + 16'd1;
                    for (i = hit + 1 - int'(w.length); i <= hit; i++)
                        owner_tbl[i] = handle_ctr;
                    push_result(STAT_OK, handle_ctr);
                end
            end
            OP_ERASE: begin
                hit = 0;
                if (w.handle != 0)
                    for (i = 0; i < m; i++)
                        if (owner_tbl[i] == w.handle) hit = 1;
                if (hit == 0) push_result(STAT_ILLEGAL, 16'd0);
                else
                    for (i = 0; i < m; i++)
                        if (owner_tbl[i] == w.handle) owner_tbl[i] = 16'd0;
            end
            OP_DEFRAG: begin
                wr = 0;
                for (i = 0; i < m; i++)
                    if (owner_tbl[i] != 0) begin
                        owner_tbl[wr] = owner_tbl[i];
                        wr++;
                    end
                for (i = wr; i < m; i++) owner_tbl[i] = 16'd0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) owner_tbl[i] = 16'd0;
            handle_ctr = 16'd0;
            cell_cnt   = MEM_SIZE_RST;
            result_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) cell_cnt = i_cfg_data;
            if (i_in_valid && !i_in_stall) apply_word(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word: status %0d handle %0d",
                                 i_out_word.status, i_out_word.new_handle);
                end else begin
                    exp_w = result_q.pop_front();
                    if (exp_w.status != i_out_word.status
                            || exp_w.new_handle != i_out_word.new_handle) begin
                        fails++;
                        if (fails <= 10)
                            $display("result mismatch: exp status %0d handle %0d, got %0d %0d",
                                     exp_w.status, exp_w.new_handle,
                                     i_out_word.status, i_out_word.new_handle);
                    end
                end
            end
        end
    end

endmodule

// File: tb/tb_first_fit_block_allocator_unit.sv
// Testbench top for the first-fit allocator: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_WAIT  = 700;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_word   i_word;
    logic       o_valid;
    logic       i_stall;
    t_out_word  o_word;
    logic       i_cfg_we;
    logic [8:0] i_cfg_data;

    int fail_cnt;
    int pending;
    int snd_idle;
    int rcv_idle;
    int cycles;
    int allocs_sent;
    logic hold_go;
    logic hold_used;
    int   hold_left;

    first_fit_block_allocator_unit #(.MEM_CELLS(256)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_word(i_word),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    ffba_alloc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_word(i_word),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= 3000;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    task automatic send(input t_in_word w);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        if (w.op == OP_ALLOC) allocs_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic mk_send(input logic [1:0] op, input int len, input int st,
                           input logic hs, input int h);
        t_in_word w;
        w.op         = op;
        w.length     = len[8:0];
        w.start_cell = st[8:0];
        w.has_start  = hs;
        w.handle     = h[15:0];
        send(w);
    endtask

    // waits out all results and any trailing erase or defragment
    task automatic set_size(input int v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        t_in_word w;
        int r;
        int lo;
        r = $urandom_range(99);
        w = t_in_word'({$urandom, $urandom});
        if (r < 50) begin
            w.op = OP_ALLOC;
            w.length = 9'(($urandom_range(9) == 0) ? $urandom_range(511)
                                                   : $urandom_range(1, 16));
            w.has_start = ($urandom_range(3) == 0);
            if ($urandom_range(3) != 0) w.start_cell = 9'($urandom_range(0, 64));
        end else if (r < 82) begin
            w.op = OP_ERASE;
            lo = (allocs_sent > 20) ? allocs_sent - 20 : 0;
            if ($urandom_range(7) != 0) w.handle = 16'($urandom_range(lo, allocs_sent + 2));
        end else if (r < 92) begin
            w.op = OP_DEFRAG;
        end else if (r < 96) begin
            w.op = OP_NOP;
        end
        send(w);
    endtask

    initial begin
        int sizes [8] = '{1, 7, 16, 64, 200, 256, 300, 511};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        cycles      = 0;
        allocs_sent = 0;
        hold_go     = 1'b0;
        snd_idle    = 13;
        rcv_idle    = 67;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners at the reset size, then at sizes 0, 1 and 511
        mk_send(OP_ALLOC, 0, 0, 0, 0);
        mk_send(OP_ALLOC, 256, 0, 0, 0);
        mk_send(OP_ALLOC, 1, 0, 0, 0);
        mk_send(OP_ERASE, 0, 0, 0, 0);
        mk_send(OP_ERASE, 0, 0, 0, 1);
        mk_send(OP_ERASE, 0, 0, 0, 1);
        mk_send(OP_ALLOC, 5, 0, 1, 0);
        mk_send(OP_ALLOC, 3, 256, 1, 0);
        mk_send(OP_ALLOC, 1, 256, 1, 0);
        mk_send(OP_ALLOC, 511, 0, 0, 65535);
        mk_send(OP_ALLOC, 2, 511, 1, 0);
        mk_send(OP_ALLOC, 4, 300, 0, 0);
        mk_send(OP_ERASE, 511, 511, 1, 2);
        mk_send(OP_DEFRAG, 0, 0, 0, 0);
        mk_send(OP_NOP, 511, 511, 1, 65535);
        mk_send(OP_ERASE, 0, 0, 0, 65535);
        mk_send(OP_ALLOC, 10, 0, 0, 0);
        set_size(0);
        mk_send(OP_ALLOC, 1, 0, 0, 0);
        mk_send(OP_DEFRAG, 0, 0, 0, 0);
        set_size(1);
        mk_send(OP_ALLOC, 1, 0, 0, 0);
        mk_send(OP_ALLOC, 1, 1, 1, 0);
        set_size(511);
        mk_send(OP_DEFRAG, 0, 0, 0, 0);
        mk_send(OP_ALLOC, 1, 0, 0, 0);

        // random phases, one size each, idle mix changes by thirds
        for (int p = 0; p < 24; p++) begin
            if (p == 8) begin snd_idle = 67; rcv_idle = 13; end
            if (p == 16) begin snd_idle = 0; rcv_idle = 0; end
            set_size((p % 3 == 2) ? sizes[$urandom_range(7)] : 256 - $urandom_range(40));
            if (p == 4) hold_go <= 1'b1;
            repeat (48) random_word();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
